[rtl/iau_pkg.sv]
// Shared types and constants for the 64-bit integer arithmetic unit.
// No dependencies; every other file of the block imports this package.
package iau_pkg;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int SHIFT_W = 6;
  localparam int CMD_W   = 3;
  localparam int MUL16_W = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ASR   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SHL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NEG   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MUL32 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_MUL64 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_MUL16 = 3'd7;

  // One item after operand preparation, as held in the first stage.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [WORD_W-1:0]  a;
    logic [WORD_W-1:0]  b;
    logic [SHIFT_W-1:0] shift;
  } op_t;

  // True for the three multiply commands.
  function automatic logic is_mul(input logic [CMD_W-1:0] cmd);
    return (cmd == CMD_MUL32) || (cmd == CMD_MUL64) || (cmd == CMD_MUL16);
  endfunction

endpackage

[rtl/iau_alu.sv]
// Add, subtract, negate and shift datapath, registered at the second stage.
// Depends on iau_pkg for the operand struct and command codes.
module iau_alu
  import iau_pkg::*;
(
  input  logic              clk,
  input  op_t               op,
  output logic [WORD_W-1:0] alu_result
);

  logic [WORD_W-1:0] alu_next;

  // Select the non-multiply operation for the item in the first stage.
  always_comb begin
    case (op.cmd)
      CMD_ADD: alu_next = op.a + op.b;
      CMD_SUB: alu_next = op.a - op.b;
      CMD_ASR: alu_next = $unsigned($signed(op.a) >>> op.shift);
      CMD_SHL: alu_next = op.a << op.shift;
      CMD_NEG: alu_next = {WORD_W{1'b0}} - op.a;
      default: alu_next = {WORD_W{1'b0}};
    endcase
  end

  // Payload register; needs no reset.
  always_ff @(posedge clk) begin
    alu_result <= alu_next;
  end

endmodule

[rtl/iau_mul.sv]
// Low 64 bits of a 64x64 product from three 32x32 partial products.
// Partials are registered at the second stage; the combine feeds stage three.
// Depends on iau_pkg.
module iau_mul
  import iau_pkg::*;
(
  input  logic              clk,
  input  op_t               op,
  output logic [WORD_W-1:0] product
);

  logic [WORD_W-1:0] p_low_next;
  logic [HALF_W-1:0] p_ab_next;
  logic [HALF_W-1:0] p_ba_next;
  logic [WORD_W-1:0] p_low;
  logic [HALF_W-1:0] p_ab;
  logic [HALF_W-1:0] p_ba;
  logic [HALF_W-1:0] cross_sum;

  // Three unsigned 32x32 multiplies; the cross terms only add to the upper word,
  // so only their low halves are formed.
  always_comb begin
    p_low_next = op.a[HALF_W-1:0] * op.b[HALF_W-1:0];
    p_ab_next  = op.a[WORD_W-1:HALF_W] * op.b[HALF_W-1:0];
    p_ba_next  = op.a[HALF_W-1:0] * op.b[WORD_W-1:HALF_W];
  end

  always_ff @(posedge clk) begin
    p_low <= p_low_next;
    p_ab  <= p_ab_next;
    p_ba  <= p_ba_next;
  end

  // Fold the cross terms into the upper word of the low product.
  always_comb begin
    cross_sum = p_ab + p_ba;
    product   = p_low + {cross_sum, {HALF_W{1'b0}}};
  end

endmodule

[rtl/int64_arithmetic_unit.sv]
// Top level of the 64-bit integer arithmetic unit.
// Depends on iau_pkg, iau_alu and iau_mul.
//
// Pipelined 64-bit ALU with multiplier. An item is taken whenever start is
// high; busy is always low, so a new item may be issued in every cycle. Each
// item gives its result on result_value for one cycle with done high. Each
// item passes the stages of the multiplier path in order: operand
// preparation, 32x32 partial products, and the final combine and select each
// occupy one register stage. Results leave in issue order and the receiver
// must take them as they appear.
module int64_arithmetic_unit
  import iau_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [WORD_W-1:0] operand_a,
  input  logic signed [WORD_W-1:0] operand_b,
  input  logic [SHIFT_W-1:0]       shift_amount,
  output logic                     done,
  output logic signed [WORD_W-1:0] result_value
);

  op_t               s1_next;
  op_t               s1_op;
  logic              s1_valid;
  logic              s2_valid;
  logic [CMD_W-1:0]  s2_cmd;
  logic [WORD_W-1:0] alu_result;
  logic [WORD_W-1:0] product;
  logic [WORD_W-1:0] result_next;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Operand preparation: the narrow multiplies become 64x64 ones by extending
  // their operands, signed for mul32x32 and unsigned for the 16-bit operand.
  always_comb begin
    s1_next.cmd   = command;
    s1_next.shift = shift_amount;
    s1_next.a     = operand_a;
    s1_next.b     = operand_b;
    case (command)
      CMD_MUL32: begin
        s1_next.a = {{HALF_W{operand_a[HALF_W-1]}}, operand_a[HALF_W-1:0]};
        s1_next.b = {{HALF_W{operand_b[HALF_W-1]}}, operand_b[HALF_W-1:0]};
      end
      CMD_MUL16: begin
        s1_next.b = {{(WORD_W-MUL16_W){1'b0}}, operand_b[MUL16_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  // First stage payload and the command carried to the select.
  always_ff @(posedge clk) begin
    s1_op  <= s1_next;
    s2_cmd <= s1_op.cmd;
  end

  iau_alu u_alu (
    .clk        (clk),
    .op         (s1_op),
    .alu_result (alu_result)
  );

  iau_mul u_mul (
    .clk     (clk),
    .op      (s1_op),
    .product (product)
  );

  // Final select into the output register.
  assign result_next = is_mul(s2_cmd) ? product : alu_result;

  always_ff @(posedge clk) begin
    result_value <= $signed(result_next);
  end

`ifndef SYNTHESIS
  // Every accepted item yields a result at the end of the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted item produced no result after three cycles");

  // No result appears without a matching item issued earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3))
    else $error("result strobe without a matching item");

  // End-to-end check of the add path.
  a_add: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_ADD) |-> ##3
      (result_value == $past(operand_a, 3) + $past(operand_b, 3)))
    else $error("add result mismatch");

  // End-to-end check of the truncating 64x64 multiply.
  a_mul64: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_MUL64) |-> ##3
      (result_value == $past(operand_a, 3) * $past(operand_b, 3)))
    else $error("mul64x64 result mismatch");
`endif

endmodule
